@@ hdl/brl_pkg.sv @@
// Shared types and constants for the Bresenham line rasterizer.
// Holds the microcode control word, jump conditions and step codes.
// No dependencies.
`timescale 1ns / 1ps

package brl_pkg;

  // Fixed field widths of the ports
  localparam int unsigned COORD_W = 6;
  localparam int unsigned PITCH_W = 7;
  localparam int unsigned IDX_W   = 12;

  // Line pitch after reset
  localparam logic [PITCH_W-1:0] PITCH_RESET = 7'd64;

  // Step counter width and step codes of the microprogram
  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_SWAP  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_ORDER = 3'd2;
  localparam logic [STEP_W-1:0] STEP_TEST  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_EMPTY = 3'd4;
  localparam logic [STEP_W-1:0] STEP_LOOP  = 3'd5;

  // Jump conditions
  typedef enum logic [1:0] {
    COND_NEVER,
    COND_NO_START,
    COND_SPAN,
    COND_MORE
  } cond_e;

  // One control word of the microprogram
  typedef struct packed {
    logic              load;
    logic              swap;
    logic              order;
    logic              emit_px;
    logic              emit_empty;
    logic              ret;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic zero_span;
    logic last_px;
  } dp_status_t;

endpackage

@@ hdl/brl_sequencer.sv @@
// Microcode sequencer: step counter, control store and jump logic.
// Depends on brl_pkg.
`timescale 1ns / 1ps

module brl_sequencer import brl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  dp_status_t status_i,
  output ucode_t     ctrl_o,
  output logic       busy
);

  logic [STEP_W-1:0] step_q, step_d;
  ucode_t            word;
  logic              take;

  // Control store
  always_comb begin
    word = '0;
    word.ret = 1'b1;
    unique case (step_q)
      STEP_IDLE: begin
        word.load   = 1'b1;
        word.ret    = 1'b0;
        word.cond   = COND_NO_START;
        word.target = STEP_IDLE;
      end
      STEP_SWAP: begin
        word.swap = 1'b1;
        word.ret  = 1'b0;
      end
      STEP_ORDER: begin
        word.order = 1'b1;
        word.ret   = 1'b0;
      end
      STEP_TEST: begin
        word.ret    = 1'b0;
        word.cond   = COND_SPAN;
        word.target = STEP_LOOP;
      end
      STEP_EMPTY: begin
        word.emit_empty = 1'b1;
      end
      STEP_LOOP: begin
        word.emit_px = 1'b1;
        word.cond    = COND_MORE;
        word.target  = STEP_LOOP;
      end
      default: begin
        word.ret = 1'b1;
      end
    endcase
  end

  // Evaluate the jump condition
  always_comb begin
    case (word.cond)
      COND_NO_START: take = !start;
      COND_SPAN:     take = !status_i.zero_span;
      COND_MORE:     take = !status_i.last_px;
      default:       take = 1'b0;
    endcase
  end

  // Jump, return to idle, or advance
  always_comb begin
    if (take) begin
      step_d = word.target;
    end else if (word.ret) begin
      step_d = STEP_IDLE;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = word;
  assign busy   = (step_q != STEP_IDLE);

endmodule

@@ hdl/brl_datapath.sv @@
// Datapath of the line rasterizer: endpoint registers, error term,
// pixel index multiply and the registered result beat.
// Depends on brl_pkg; driven by brl_sequencer control words.
`timescale 1ns / 1ps

module brl_datapath import brl_pkg::*; #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ucode_t             ctrl_i,
  input  logic [COORD_W-1:0] start_x_i,
  input  logic [COORD_W-1:0] start_y_i,
  input  logic [COORD_W-1:0] end_x_i,
  input  logic [COORD_W-1:0] end_y_i,
  input  logic [PITCH_W-1:0] pitch_i,
  output dp_status_t         status_o,
  output logic               pixel_valid_o,
  output logic [COORD_W-1:0] pixel_x_o,
  output logic [COORD_W-1:0] pixel_y_o,
  output logic [IDX_W-1:0]   pixel_index_o,
  output logic               empty_line_o,
  output logic               last_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned EW = COORD_BITS + 3;

  logic [CB-1:0] a0_q, b0_q, a1_q, b1_q;
  logic [CB-1:0] span_x, span_y, lo_a, hi_a, lo_b, hi_b, minor_span;
  logic [CB-1:0] major_q, mspan_q, px, py;
  logic          steep_q, up_q, steep_n, flip;
  logic signed [EW-1:0] err_q, err_n, err_fix;
  logic [COORD_W-1:0]   px_w, py_w;
  logic [COORD_W+PITCH_W-1:0] prod;
  logic                 valid_q;
  logic [COORD_W-1:0]   x_q, y_q;
  logic [IDX_W-1:0]     idx_q;
  logic                 empty_q, last_q;

  // Spans of the raw endpoints and steepness
  assign span_x  = (a1_q > a0_q) ? a1_q - a0_q : a0_q - a1_q;
  assign span_y  = (b1_q > b0_q) ? b1_q - b0_q : b0_q - b1_q;
  assign steep_n = span_y > span_x;

  // Order endpoints so the major coordinate rises
  assign flip       = a0_q > a1_q;
  assign lo_a       = flip ? a1_q : a0_q;
  assign hi_a       = flip ? a0_q : a1_q;
  assign lo_b       = flip ? b1_q : b0_q;
  assign hi_b       = flip ? b0_q : b1_q;
  assign minor_span = (hi_b > lo_b) ? hi_b - lo_b : lo_b - hi_b;

  // Error update for one step
  assign err_n   = err_q - $signed({2'b00, mspan_q, 1'b0});
  assign err_fix = err_n + $signed({2'b00, major_q, 1'b0});

  // Status flags for the sequencer
  assign status_o.zero_span = (major_q == '0);
  assign status_o.last_px   = ({1'b0, a0_q} + 1'b1) == {1'b0, a1_q};

  // Current pixel and its linear index
  assign px   = steep_q ? b0_q : a0_q;
  assign py   = steep_q ? a0_q : b0_q;
  assign px_w = COORD_W'(px);
  assign py_w = COORD_W'(py);
  assign prod = py_w * pitch_i;

  // Load, swap, order and step the line registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      a0_q <= start_x_i[CB-1:0];
      b0_q <= start_y_i[CB-1:0];
      a1_q <= end_x_i[CB-1:0];
      b1_q <= end_y_i[CB-1:0];
    end else if (ctrl_i.swap) begin
      steep_q <= steep_n;
      if (steep_n) begin
        a0_q <= b0_q;
        b0_q <= a0_q;
        a1_q <= b1_q;
        b1_q <= a1_q;
      end
    end else if (ctrl_i.order) begin
      a0_q    <= lo_a;
      a1_q    <= hi_a;
      b0_q    <= lo_b;
      b1_q    <= hi_b;
      major_q <= hi_a - lo_a;
      mspan_q <= minor_span;
      up_q    <= lo_b < hi_b;
      err_q   <= $signed({3'b000, hi_a - lo_a});
    end else if (ctrl_i.emit_px) begin
      a0_q <= a0_q + 1'b1;
      if (err_n < 0) begin
        b0_q  <= up_q ? b0_q + 1'b1 : b0_q - 1'b1;
        err_q <= err_fix;
      end else begin
        err_q <= err_n;
      end
    end
  end

  // Capture the result beat
  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit_empty) begin
      x_q     <= '0;
      y_q     <= '0;
      idx_q   <= '0;
      empty_q <= 1'b1;
      last_q  <= 1'b1;
    end else if (ctrl_i.emit_px) begin
      x_q     <= px_w;
      y_q     <= py_w;
      idx_q   <= IDX_W'(prod + (COORD_W + PITCH_W)'(px_w));
      empty_q <= 1'b0;
      last_q  <= status_o.last_px;
    end
  end

  // Strobe for one cycle per beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl_i.emit_px | ctrl_i.emit_empty;
    end
  end

  assign pixel_valid_o = valid_q;
  assign pixel_x_o     = x_q;
  assign pixel_y_o     = y_q;
  assign pixel_index_o = idx_q;
  assign empty_line_o  = empty_q;
  assign last_o        = last_q;

endmodule

@@ hdl/bresenham_line_rasterizer.sv @@
// Top level of the Bresenham line rasterizer: line pitch register,
// microcode sequencer and datapath.
// Depends on brl_pkg, brl_sequencer and brl_datapath.
`timescale 1ns / 1ps

// Usage:
//   Present both endpoints on start_x_i/start_y_i/end_x_i/end_y_i and pulse
//   start while busy is low; the line is taken at that clock edge.
//   Pixels come out one per cycle in order, each beat marked by a one-cycle
//   pixel_valid_o with pixel_x_o, pixel_y_o and pixel_index_o
//   (row * pitch + column, low 12 bits). last_o flags the final beat.
//   A line whose endpoints coincide gives a single beat with empty_line_o
//   and last_o set and zero coordinates.
//   The first beat follows three setup steps of the microprogram (swap,
//   order, test), then one loop step per pixel on the shared datapath, or
//   one empty step. A new line is accepted only once the sequencer is idle.
//   line_pitch_i is written when line_pitch_we_i is high; the user must
//   write it only while idle; the block does not enforce this. Reset
//   returns the sequencer to idle, drops the strobe and sets the
//   pitch to 64. Beats cannot be held off by the receiver.

module bresenham_line_rasterizer import brl_pkg::*; #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               line_pitch_we_i,
  input  logic [PITCH_W-1:0] line_pitch_i,
  input  logic               start,
  output logic               busy,
  input  logic [COORD_W-1:0] start_x_i,
  input  logic [COORD_W-1:0] start_y_i,
  input  logic [COORD_W-1:0] end_x_i,
  input  logic [COORD_W-1:0] end_y_i,
  output logic               pixel_valid_o,
  output logic [COORD_W-1:0] pixel_x_o,
  output logic [COORD_W-1:0] pixel_y_o,
  output logic [IDX_W-1:0]   pixel_index_o,
  output logic               empty_line_o,
  output logic               last_o
);

  logic [PITCH_W-1:0] pitch_q;
  ucode_t             ctrl;
  dp_status_t         status;

  // Hold the line pitch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q <= PITCH_RESET;
    end else if (line_pitch_we_i) begin
      pitch_q <= line_pitch_i;
    end
  end

  brl_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy     (busy)
  );

  brl_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .pitch_i       (pitch_q),
    .status_o      (status),
    .pixel_valid_o (pixel_valid_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_index_o (pixel_index_o),
    .empty_line_o  (empty_line_o),
    .last_o        (last_o)
  );

endmodule
